>>> rtl/core/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and defaults for the running median tracker
// Default sizes, the per-cell command and the flags a cell hands to its
// right-hand neighbor.
// ----------------------------------------------------------------------------
package rmt_pkg;

  localparam int unsigned CAPACITY_DEF    = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // command broadcast along one chain
  typedef struct packed {
    logic insert;   // sorted insert of the key
    logic replace;  // drop the top, then sorted insert of the key
  } rmt_cmd_t;

  // flags each cell passes to its right-hand neighbor
  typedef struct packed {
    logic keep;     // insert: this cell holds its word
    logic shift;    // replace: this cell pulls from its right neighbor
  } rmt_flags_t;

endpackage

>>> rtl/core/rmt_ifs.sv
// ----------------------------------------------------------------------------
// rmt_ifs: valid/ready channels of the running median tracker
// Sample input channel and result output channel.
// ----------------------------------------------------------------------------
interface rmt_sample_if #(
  parameter int unsigned SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmt_result_if #(
  parameter int unsigned SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;
  logic                          full_res;

  modport source (output valid, output median, output full_res, input ready);
  modport sink   (input valid, input median, input full_res, output ready);
endinterface

>>> rtl/core/rmt_cell.sv
// ----------------------------------------------------------------------------
// rmt_cell: one slot of a sorted chain
// Holds one word. The chain keeps its best word (largest or smallest) at
// slot 0. Insert shifts words right from the key's place; replace drops the
// top and shifts words left up to the key's place.
// ----------------------------------------------------------------------------
module rmt_cell #(
  parameter int unsigned SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CNT_W       = 11,
  parameter int unsigned INDEX       = 0,
  parameter bit          MAX_FIRST   = 1'b1
) (
  input  logic                          clk,
  input  rmt_pkg::rmt_cmd_t             cmd,
  input  logic signed [SAMPLE_BITS-1:0] key,
  input  logic [CNT_W-1:0]              count,
  input  logic signed [SAMPLE_BITS-1:0] left_q,
  input  rmt_pkg::rmt_flags_t           left_flags,
  input  logic signed [SAMPLE_BITS-1:0] right_q,
  output logic signed [SAMPLE_BITS-1:0] q,
  output logic signed [SAMPLE_BITS-1:0] d,
  output rmt_pkg::rmt_flags_t           flags
);
  import rmt_pkg::*;

  logic occ;
  logic right_occ;
  logic beats_own;
  logic beats_right;

  assign occ       = 32'(count) > 32'(INDEX);
  assign right_occ = 32'(count) > 32'(INDEX + 1);

  // key ranks ahead of a stored word (strictly)
  assign beats_own   = MAX_FIRST ? (key > q)       : (key < q);
  assign beats_right = MAX_FIRST ? (key > right_q) : (key < right_q);

  assign flags.keep  = occ && !beats_own;
  assign flags.shift = right_occ && !beats_right;

  always_comb begin
    d = q;
    if (cmd.insert) begin
      if (flags.keep) begin
        d = q;
      end else if (left_flags.keep) begin
        d = key;
      end else begin
        d = left_q;
      end
    end else if (cmd.replace) begin
      if (flags.shift) begin
        d = right_q;
      end else if (left_flags.shift) begin
        d = key;
      end else begin
        d = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= d;
  end

endmodule

>>> rtl/core/running_median_tracker_core.sv
// ----------------------------------------------------------------------------
// running_median_tracker_core: running lower median over signed samples
// Output: the result word for a sample is registered and valid in the cycle
//   after the sample word is accepted.
// Throughput: 1 sample per cycle unless results stall; every cell of both
//   chains updates in the accept cycle, so nothing waits on an earlier sample.
// Reset: synchronous rst clears both fill counts and the output valid; cell
//   contents are not cleared and are only read below the fill counts.
// ----------------------------------------------------------------------------
module running_median_tracker_core #(
  parameter int unsigned CAPACITY    = rmt_pkg::CAPACITY_DEF,
  parameter int unsigned SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  rmt_sample_if.sink  samples,
  rmt_result_if.source results
);
  import rmt_pkg::*;

  // Lower half: descending chain, slot 0 is its max (the median).
  // Upper half: ascending chain, slot 0 is its min.
  localparam int unsigned LO_DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned UP_DEPTH = CAPACITY / 2;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] lower_count;
  logic [CNT_W-1:0] upper_count;

  logic signed [SAMPLE_BITS-1:0] lo_q [LO_DEPTH];
  logic signed [SAMPLE_BITS-1:0] lo_d [LO_DEPTH];
  rmt_flags_t                    lo_flags [LO_DEPTH];
  logic signed [SAMPLE_BITS-1:0] up_q [UP_DEPTH];
  logic signed [SAMPLE_BITS-1:0] up_d [UP_DEPTH];
  rmt_flags_t                    up_flags [UP_DEPTH];

  rmt_cmd_t                      lo_cmd;
  rmt_cmd_t                      up_cmd;
  logic signed [SAMPLE_BITS-1:0] lo_key;
  logic signed [SAMPLE_BITS-1:0] up_key;

  logic                          accept;
  logic                          full;
  logic                          even;
  logic                          go;
  logic                          x_high;
  logic                          x_low;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] l0;
  logic signed [SAMPLE_BITS-1:0] u0;

  // --------------------------------------------------------------------------
  // Handshake: the output register frees up when its word is taken, so a
  // new sample goes in while the previous result is being drained.
  // --------------------------------------------------------------------------
  assign samples.ready = !results.valid || results.ready;
  assign accept        = samples.valid && samples.ready;

  assign full = ({1'b0, lower_count} + {1'b0, upper_count}) >= (CNT_W + 1)'(CAPACITY);
  assign even = lower_count == upper_count;
  assign go   = accept && !full;

  assign x  = samples.sample;
  assign l0 = lo_q[0];
  assign u0 = up_q[0];

  // Equal halves: the smaller of sample and upper top joins the lower half;
  // if the sample is above the upper top, it replaces that top.
  assign x_high = (upper_count != '0) && (x > u0);
  // Lower half ahead by one: the larger of sample and lower top joins the
  // upper half; if the sample is below the lower top, it replaces that top.
  assign x_low  = x < l0;

  always_comb begin
    lo_cmd.insert  = go && even;
    lo_cmd.replace = go && !even && x_low;
    lo_key         = (even && x_high) ? u0 : x;
    up_cmd.insert  = go && !even;
    up_cmd.replace = go && even && x_high;
    up_key         = (!even && !x_low) ? x : (even ? x : l0);
  end

  // --------------------------------------------------------------------------
  // Cell chains. Slot 0 sees "keep/shift" true on its left so that it takes
  // the key when its own word loses; the last slot has no right neighbor.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < LO_DEPTH; i++) begin : g_lo
    logic signed [SAMPLE_BITS-1:0] left_q;
    logic signed [SAMPLE_BITS-1:0] right_q;
    rmt_flags_t                    left_flags;

    if (i == 0) begin : g_first
      assign left_q     = lo_q[i];
      assign left_flags = '{keep: 1'b1, shift: 1'b1};
    end else begin : g_mid
      assign left_q     = lo_q[i-1];
      assign left_flags = lo_flags[i-1];
    end
    if (i == LO_DEPTH - 1) begin : g_last
      assign right_q = lo_q[i];
    end else begin : g_inner
      assign right_q = lo_q[i+1];
    end

    rmt_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_W      (CNT_W),
      .INDEX      (i),
      .MAX_FIRST  (1'b1)
    ) u_cell (
      .clk       (clk),
      .cmd       (lo_cmd),
      .key       (lo_key),
      .count     (lower_count),
      .left_q    (left_q),
      .left_flags(left_flags),
      .right_q   (right_q),
      .q         (lo_q[i]),
      .d         (lo_d[i]),
      .flags     (lo_flags[i])
    );
  end

  for (genvar i = 0; i < UP_DEPTH; i++) begin : g_up
    logic signed [SAMPLE_BITS-1:0] left_q;
    logic signed [SAMPLE_BITS-1:0] right_q;
    rmt_flags_t                    left_flags;

    if (i == 0) begin : g_first
      assign left_q     = up_q[i];
      assign left_flags = '{keep: 1'b1, shift: 1'b1};
    end else begin : g_mid
      assign left_q     = up_q[i-1];
      assign left_flags = up_flags[i-1];
    end
    if (i == UP_DEPTH - 1) begin : g_last
      assign right_q = up_q[i];
    end else begin : g_inner
      assign right_q = up_q[i+1];
    end

    rmt_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_W      (CNT_W),
      .INDEX      (i),
      .MAX_FIRST  (1'b0)
    ) u_cell (
      .clk       (clk),
      .cmd       (up_cmd),
      .key       (up_key),
      .count     (upper_count),
      .left_q    (left_q),
      .left_flags(left_flags),
      .right_q   (right_q),
      .q         (up_q[i]),
      .d         (up_d[i]),
      .flags     (up_flags[i])
    );
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count <= '0;
      upper_count <= '0;
    end else if (go) begin
      if (even) begin
        lower_count <= lower_count + CNT_W'(1);
      end else begin
        upper_count <= upper_count + CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output word: median is the next value of the lower top, so it is right
  // even while the chains move on to the following sample.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.median   <= lo_d[0];
      results.full_res <= full;
    end
  end

`ifndef ASSERT_OFF
  // halves stay balanced, lower ahead by at most one
  a_balance: assert property (@(posedge clk) disable iff (rst)
    (lower_count == upper_count) || (lower_count == upper_count + CNT_W'(1)))
    else $error("halves out of balance");

  // lower top never ranks above upper top
  a_split: assert property (@(posedge clk) disable iff (rst)
    (upper_count != '0) |-> (lo_q[0] <= up_q[0]))
    else $error("lower top above upper top");

  // a full store leaves the counts alone
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |=> ($stable(lower_count) && $stable(upper_count)))
    else $error("count moved while full");

  // every accepted sample yields a result word next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> results.valid)
    else $error("result word missing");
`endif

endmodule

>>> test/rmt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmt_checker: result checker for the running median tracker
// Watches both channels, keeps its own split of the held samples into a
// lower and an upper half, and compares every result word with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module rmt_checker #(
  parameter int unsigned CAPACITY    = rmt_pkg::CAPACITY_DEF,
  parameter int unsigned SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rmt_sample_if       smp,
  rmt_result_if       res,
  output int unsigned fails,
  output int unsigned pending,
  output int unsigned medians_seen,
  output int unsigned full_seen
);

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  typedef struct packed {
    smp_t median;
    logic full_res;
  } median_word_t;

  // both halves ascending: lower top is the last entry, upper top the first
  smp_t         lower_q[$];
  smp_t         upper_q[$];
  median_word_t median_due_q[$];

  initial begin
    fails        = 0;
    pending      = 0;
    medians_seen = 0;
    full_seen    = 0;
  end

  task automatic report_mismatch(input string what);
    fails++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void place_sorted(ref smp_t q[$], input smp_t v);
    int pos;
    pos = q.size();
    while (pos > 0 && q[pos-1] > v) pos--;
    q.insert(pos, v);
  endfunction

  function automatic median_word_t advance_halves(input smp_t v);
    median_word_t w;
    smp_t         lo_top;
    smp_t         up_top;
    w.full_res = 1'b0;
    if (lower_q.size() + upper_q.size() >= CAPACITY) begin
      w.full_res = 1'b1;
    end else begin
      if (lower_q.size() == upper_q.size()) place_sorted(lower_q, v);
      else place_sorted(upper_q, v);
      if (lower_q.size() > 0 && upper_q.size() > 0 && lower_q[$] > upper_q[0]) begin
        lo_top = lower_q.pop_back();
        up_top = upper_q.pop_front();
        place_sorted(lower_q, up_top);
        place_sorted(upper_q, lo_top);
      end
    end
    w.median = (lower_q.size() > 0) ? lower_q[$] : '0;
    return w;
  endfunction

  // prediction is queued before the compare so a same-edge result still lines up
  always @(posedge clk) begin
    median_word_t want;
    if (!rst) begin
      if (smp.valid && smp.ready) median_due_q.push_back(advance_halves(smp.sample));
      if (res.valid && res.ready) begin
        medians_seen++;
        if (res.full_res === 1'b1) full_seen++;
        if (median_due_q.size() == 0) begin
          report_mismatch($sformatf("result word with nothing due: median %0d full %b",
                                    res.median, res.full_res));
        end else begin
          want = median_due_q.pop_front();
          if (res.median !== want.median)
            report_mismatch($sformatf("median %0d, want %0d", res.median, want.median));
          if (res.full_res !== want.full_res)
            report_mismatch($sformatf("full_res %b, want %b", res.full_res, want.full_res));
        end
      end
      pending = median_due_q.size();
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for running_median_tracker_core
// Drives a directed run of extreme and tie-heavy samples, then random
// samples through several handshake phases until the store fills and
// refuses words; results are checked by rmt_checker.
// ----------------------------------------------------------------------------
module tb;

  import rmt_pkg::*;

  localparam int unsigned CAP   = CAPACITY_DEF;
  localparam int unsigned SB    = SAMPLE_BITS_DEF;
  localparam int unsigned LIMIT = 400000;  // cycles; far above the slowest run
  localparam int unsigned N_RANDOM  = 1050;
  localparam int unsigned PER_PHASE = 210;
  localparam int unsigned HOLD_LEN  = 300;  // long receiver hold-off

  typedef logic signed [SB-1:0] smp_t;

  // handshake mix of the current stretch of stimulus
  typedef enum logic [2:0] {
    PH_STEADY,        // no idling on either side
    PH_SRC_GAPS,      // sender idle 84 of 100 tries
    PH_SNK_STALLS,    // receiver stalling 84 of 100
    PH_BOTH_IDLE,     // both at 25 of 100
    PH_BACKPRESSURE   // long receiver hold-off, sender keeps offering
  } phase_t;

  localparam smp_t MAX_S = {1'b0, {(SB-1){1'b1}}};
  localparam smp_t MIN_S = {1'b1, {(SB-1){1'b0}}};

  logic        clk = 1'b0;
  logic        rst;
  phase_t      phase;
  int unsigned cycles;
  int unsigned n_sent;
  int unsigned fails, pending, medians_seen, full_seen;

  rmt_sample_if #(.SAMPLE_BITS(SB)) smp_ch ();
  rmt_result_if #(.SAMPLE_BITS(SB)) res_ch ();

  running_median_tracker_core #(
    .CAPACITY    (CAP),
    .SAMPLE_BITS (SB)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (smp_ch),
    .results (res_ch)
  );

  rmt_checker #(
    .CAPACITY    (CAP),
    .SAMPLE_BITS (SB)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .smp          (smp_ch),
    .res          (res_ch),
    .fails        (fails),
    .pending      (pending),
    .medians_seen (medians_seen),
    .full_seen    (full_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit: anything past this is a hang
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT) begin
        $display("timeout after %0d cycles, %0d words still due", cycles, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: one ready decision per cycle. On first entry into the
  // backpressure phase it holds ready low for a long hold-off, counted
  // here, so the core fills its output and must drop samples.ready.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    int unsigned stall_pct;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case (phase)
        PH_SNK_STALLS: stall_pct = 84;
        PH_BOTH_IDLE:  stall_pct = 25;
        default:       stall_pct = 0;
      endcase
      if (phase == PH_BACKPRESSURE && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one sample word and return right after the edge that took it.
  // valid stays high into the next call, so back-to-back words need no gap.
  task automatic send_sample(input smp_t v);
    int unsigned idle_pct;
    case (phase)
      PH_SRC_GAPS:  idle_pct = 84;
      PH_BOTH_IDLE: idle_pct = 25;
      default:      idle_pct = 0;
    endcase
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.valid  <= 1'b1;
    smp_ch.sample <= v;
    do @(posedge clk); while (smp_ch.ready !== 1'b1);
    n_sent++;
  endtask

  // Directed words: both extremes, zero and -1, ties, a descending run that
  // forces a swap of the two tops on two of its five words, an ascending run, and
  // alternating bit patterns.
  smp_t directed[$] = '{
    smp_t'(0), MAX_S, MIN_S, smp_t'(-1), smp_t'(1), MAX_S, MIN_S,
    smp_t'(100), smp_t'(100), smp_t'(100), smp_t'(-100),
    smp_t'(5), smp_t'(4), smp_t'(3), smp_t'(2), smp_t'(1),
    smp_t'(50), smp_t'(51), smp_t'(52),
    MIN_S, MAX_S, smp_t'(21845), smp_t'(-21846), smp_t'(-1)
  };

  initial begin
    smp_t v;
    smp_t ramp;
    smp_t ramp_step;
    n_sent = 0;
    phase  = PH_STEADY;
    rst          <= 1'b1;
    smp_ch.valid  <= 1'b0;
    smp_ch.sample <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_sample(directed[i]);

    ramp      = '0;
    ramp_step = smp_t'(7);
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      // five equal stretches, one per handshake mix
      phase = phase_t'(i / PER_PHASE);
      case ($urandom_range(9))
        0:       v = $urandom_range(1) ? MAX_S : MIN_S;
        1, 2, 3: v = smp_t'($urandom_range(16) - 8);   // dense ties around zero
        4, 5: begin
          // monotonic runs stress insertion at one end of a half
          if ($urandom_range(15) == 0) ramp_step = smp_t'($urandom_range(64) - 32);
          ramp = ramp + ramp_step;
          v    = ramp;
        end
        default: v = smp_t'($urandom);
      endcase
      send_sample(v);
    end
    smp_ch.valid <= 1'b0;

    // drain, then leave room for a stray late word
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d sample words: directed extremes and ties, then random words",
             n_sent);
    $display("over five handshake mixes; %0d result words, %0d refused with the store full",
             medians_seen, full_seen);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fails);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
